// File: sv/euler_zyx_from_rotation_defines.svh
// Assertion macros used by the checker file ezr_checker.
`ifndef EULER_ZYX_FROM_ROTATION_DEFINES_SVH
`define EULER_ZYX_FROM_ROTATION_DEFINES_SVH

// Checked only outside reset.
`define EZR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define EZR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/ezr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ezr_pkg;

  localparam int CordicSteps = 16;
  localparam int EntryWidth  = 16;

  localparam int DW = 36;  // CORDIC x/y width
  localparam int AW = 34;  // angle width, rad * 2^30

  localparam logic signed [AW-1:0] ANG_HALF_PI = 34'sd1686629713;
  localparam logic [29:0]          INV_GAIN    = 30'd652032874;
  localparam logic signed [15:0]   OUT_MAX     = 16'sd25736;
  localparam logic signed [15:0]   OUT_HALF_PI = 16'sd12868;

  typedef enum logic [1:0] {
    BR_REGULAR  = 2'd0,
    BR_NEAR_POS = 2'd1,
    BR_NEAR_NEG = 2'd2
  } branch_t;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [AW-1:0] z;
  } lane_t;

  typedef struct packed {
    branch_t              branch;
    logic                 za;
    logic                 zg;
    logic                 zb;
    logic signed [DW-1:0] neg_r20;
    logic [32:0]          mag;
    logic signed [15:0]   alpha_q;
    logic signed [15:0]   gamma_q;
  } side_t;

  function automatic logic signed [AW-1:0] atan_entry(input int i);
    logic signed [AW-1:0] v;
    case (i)
      0:  v = 34'sh3243F6A8;
      1:  v = 34'sh1DAC6705;
      2:  v = 34'sh0FADBAFC;
      3:  v = 34'sh07F56EA6;
      4:  v = 34'sh03FEAB76;
      5:  v = 34'sh01FFD55B;
      6:  v = 34'sh00FFFAAA;
      7:  v = 34'sh007FFF55;
      8:  v = 34'sh003FFFEA;
      9:  v = 34'sh001FFFFD;
      10: v = 34'sh000FFFFF;
      11: v = 34'sh0007FFFF;
      12: v = 34'sh0003FFFF;
      13: v = 34'sh0001FFFF;
      14: v = 34'sh0000FFFF;
      15: v = 34'sh00007FFF;
      16: v = 34'sh00003FFF;
      17: v = 34'sh00001FFF;
      18: v = 34'sh00000FFF;
      19: v = 34'sh000007FF;
      20: v = 34'sh000003FF;
      21: v = 34'sh000001FF;
      22: v = 34'sh000000FF;
      23: v = 34'sh0000007F;
      24: v = 34'sh0000003F;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Fold the left half plane onto the right one by a quarter turn.
  function automatic lane_t prerotate(input logic signed [DW-1:0] x,
                                      input logic signed [DW-1:0] y);
    lane_t l;
    l.x = x;
    l.y = y;
    l.z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        l.x = y;
        l.y = -x;
        l.z = ANG_HALF_PI;
      end else begin
        l.x = -y;
        l.y = x;
        l.z = -ANG_HALF_PI;
      end
    end
    return l;
  endfunction

  // Round to Q2.13 and clamp to +-pi.
  function automatic logic signed [15:0] to_q213(input logic signed [AW-1:0] z);
    logic signed [AW:0] t;
    logic signed [15:0] r;
    t = (AW'(z) + (AW+1)'(65536)) >>> 17;
    if (t > (AW+1)'(OUT_MAX)) begin
      r = OUT_MAX;
    end else if (t < -(AW+1)'(OUT_MAX)) begin
      r = -OUT_MAX;
    end else begin
      r = t[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/ezr_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ezr_in_if #(
  parameter int ENTRY_WIDTH = ezr_pkg::EntryWidth
);
  logic                          valid;
  logic                          ready;
  logic signed [ENTRY_WIDTH-1:0] r00;
  logic signed [ENTRY_WIDTH-1:0] r10;
  logic signed [ENTRY_WIDTH-1:0] r20;
  logic signed [ENTRY_WIDTH-1:0] r01;
  logic signed [ENTRY_WIDTH-1:0] r11;
  logic signed [ENTRY_WIDTH-1:0] r21;
  logic signed [ENTRY_WIDTH-1:0] r22;

  modport source (output valid, r00, r10, r20, r01, r11, r21, r22, input ready);
  modport sink   (input valid, r00, r10, r20, r01, r11, r21, r22, output ready);
endinterface
`default_nettype wire

// File: sv/ezr_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ezr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] alpha_z;
  logic signed [15:0] beta_y;
  logic signed [15:0] gamma_x;
  logic [1:0]         branch_taken;

  modport source (output valid, alpha_z, beta_y, gamma_x, branch_taken, input ready);
  modport sink   (input valid, alpha_z, beta_y, gamma_x, branch_taken, output ready);
endinterface
`default_nettype wire

// File: sv/euler_zyx_from_rotation.sv
`timescale 1ns / 1ps
`default_nettype none
// Z-Y-X Euler angles from a rotation matrix.
// in_ch carries one matrix per beat: r00, r10, r20, r01, r11, r21, r22 in signed
// Q1.(ENTRY_WIDTH-2). out_ch returns one beat per matrix: alpha_z, beta_y, gamma_x
// in signed Q2.13 radians and branch_taken (regular, r20 near +1, r20 near -1).
// cfg_we/cfg_wdata write the gimbal-lock tolerance; write it only while idle.
// From input beat to output beat a matrix passes an entry stage, a row of CORDIC
// cells for alpha/magnitude and gamma, a gain multiply stage, a beta entry stage,
// a second row of cells for beta, and the output register. Throughput is one
// matrix per cycle while out_ch is not stalled; the whole chain of cells advances
// together, one cell per cycle.
// When out_ch stalls, the chain holds and in_ch.ready drops until the waiting
// beat is taken; no beat is lost or repeated.
// Reset clears all valid bits and sets the tolerance to 1; payload registers
// are not reset.
module euler_zyx_from_rotation #(
  parameter int CORDIC_STEPS = ezr_pkg::CordicSteps,
  parameter int ENTRY_WIDTH  = ezr_pkg::EntryWidth
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cfg_we,
  input  wire logic [9:0] cfg_wdata,
  ezr_in_if.sink     in_ch,
  ezr_out_if.source  out_ch
);

  localparam int N   = CORDIC_STEPS;
  localparam int TOT = 2 * N + 4;
  localparam int DW  = ezr_pkg::DW;
  localparam int EW  = ENTRY_WIDTH;
  localparam int SH  = 32 - EW;

  logic [9:0]     tol_r;
  logic           en;
  logic [TOT-1:0] vld_r;

  ezr_pkg::side_t side_r   [0:TOT-2];
  ezr_pkg::side_t side_nxt [0:TOT-2];
  ezr_pkg::side_t side_in;
  ezr_pkg::lane_t lane_a [0:N];
  ezr_pkg::lane_t lane_g [0:N];
  ezr_pkg::lane_t lane_b [0:N];
  ezr_pkg::lane_t lane_a0_nxt, lane_g0_nxt, lane_b0_nxt;
  ezr_pkg::lane_t lane_a0_r, lane_g0_r, lane_b0_r;

  logic signed [DW-1:0] op00, op10, op20, op01, op11, op21, op22;
  logic signed [EW+1:0] dp, dm, adp, adm;
  ezr_pkg::branch_t     br_in;
  logic [62:0]          prod;

  logic signed [15:0] alpha_nxt, beta_nxt, gamma_nxt;
  logic signed [15:0] alpha_r, beta_r, gamma_r, q_tmp;
  logic [1:0]         branch_r;

  // Advance the whole chain unless the output beat is stuck.
  assign en          = !vld_r[TOT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= 10'd1;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOT-2:0], in_ch.valid};
    end
  end

  // Entry stage: scale operands, detect gimbal lock, pick the gamma pair.
  always_comb begin
    op00 = DW'(in_ch.r00) <<< SH;
    op10 = DW'(in_ch.r10) <<< SH;
    op20 = DW'(in_ch.r20) <<< SH;
    op01 = DW'(in_ch.r01) <<< SH;
    op11 = DW'(in_ch.r11) <<< SH;
    op21 = DW'(in_ch.r21) <<< SH;
    op22 = DW'(in_ch.r22) <<< SH;

    dp  = (EW+2)'(in_ch.r20) - ((EW+2)'(1) <<< (EW - 2));
    dm  = (EW+2)'(in_ch.r20) + ((EW+2)'(1) <<< (EW - 2));
    adp = (dp < 0) ? -dp : dp;
    adm = (dm < 0) ? -dm : dm;

    if (adp < $signed({{(EW-8){1'b0}}, tol_r})) begin
      br_in = ezr_pkg::BR_NEAR_POS;
    end else if (adm < $signed({{(EW-8){1'b0}}, tol_r})) begin
      br_in = ezr_pkg::BR_NEAR_NEG;
    end else begin
      br_in = ezr_pkg::BR_REGULAR;
    end

    lane_a0_nxt = ezr_pkg::prerotate(op00, op10);
    if (br_in == ezr_pkg::BR_REGULAR) begin
      lane_g0_nxt = ezr_pkg::prerotate(op22, op21);
    end else begin
      lane_g0_nxt = ezr_pkg::prerotate(op11, op01);
    end

    side_in         = '0;
    side_in.branch  = br_in;
    side_in.za      = (op00 == 0) && (op10 == 0);
    side_in.zg      = (br_in == ezr_pkg::BR_REGULAR) ? ((op22 == 0) && (op21 == 0))
                                                     : ((op11 == 0) && (op01 == 0));
    side_in.neg_r20 = -op20;
  end

  // Gain stage: scale the magnitude by 1/K, round the first two angles; then set up the beta entry lane.
  assign prod = {30'd0, lane_a[N].x[32:0]} * {33'd0, ezr_pkg::INV_GAIN};

  always_comb begin
    side_nxt[0] = side_in;
    for (int k = 1; k < TOT - 1; k++) begin
      side_nxt[k] = side_r[k-1];
    end
    side_nxt[N+1].mag     = prod[62:30];
    side_nxt[N+1].alpha_q = side_r[N].za ? 16'sd0 : ezr_pkg::to_q213(lane_a[N].z);
    q_tmp                 = side_r[N].zg ? 16'sd0 : ezr_pkg::to_q213(lane_g[N].z);
    side_nxt[N+1].gamma_q = (side_r[N].branch == ezr_pkg::BR_NEAR_POS) ? -q_tmp : q_tmp;
    side_nxt[N+2].zb      = (side_r[N+1].mag == '0) && (side_r[N+1].neg_r20 == 0);
    lane_b0_nxt = ezr_pkg::prerotate(DW'(side_r[N+1].mag), side_r[N+1].neg_r20);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < TOT - 1; k++) begin
        side_r[k] <= side_nxt[k];
      end
      lane_a0_r <= lane_a0_nxt;
      lane_g0_r <= lane_g0_nxt;
      lane_b0_r <= lane_b0_nxt;
    end
  end

  assign lane_a[0] = lane_a0_r;
  assign lane_g[0] = lane_g0_r;
  assign lane_b[0] = lane_b0_r;

  for (genvar k = 0; k < N; k++) begin : g_cells
    ezr_cell #(.STEP(k)) u_cell_a (
      .clk(clk), .en(en), .lane_in(lane_a[k]), .lane_out(lane_a[k+1])
    );
    ezr_cell #(.STEP(k)) u_cell_g (
      .clk(clk), .en(en), .lane_in(lane_g[k]), .lane_out(lane_g[k+1])
    );
    ezr_cell #(.STEP(k)) u_cell_b (
      .clk(clk), .en(en), .lane_in(lane_b[k]), .lane_out(lane_b[k+1])
    );
  end

  // Output stage: pick beta by branch, hold the beat until taken.
  always_comb begin
    alpha_nxt = side_r[TOT-2].alpha_q;
    gamma_nxt = side_r[TOT-2].gamma_q;
    case (side_r[TOT-2].branch)
      ezr_pkg::BR_NEAR_POS: begin
        beta_nxt  = -ezr_pkg::OUT_HALF_PI;
        alpha_nxt = '0;
      end
      ezr_pkg::BR_NEAR_NEG: begin
        beta_nxt  = ezr_pkg::OUT_HALF_PI;
        alpha_nxt = '0;
      end
      default: begin
        beta_nxt = side_r[TOT-2].zb ? 16'sd0 : ezr_pkg::to_q213(lane_b[N].z);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      alpha_r  <= alpha_nxt;
      beta_r   <= beta_nxt;
      gamma_r  <= gamma_nxt;
      branch_r <= side_r[TOT-2].branch;
    end
  end

  assign out_ch.valid        = vld_r[TOT-1];
  assign out_ch.alpha_z      = alpha_r;
  assign out_ch.beta_y       = beta_r;
  assign out_ch.gamma_x      = gamma_r;
  assign out_ch.branch_taken = branch_r;

endmodule
`default_nettype wire

// File: sv/ezr_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module ezr_cell #(
  parameter int STEP = 0
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire ezr_pkg::lane_t lane_in,
  output ezr_pkg::lane_t      lane_out
);

  ezr_pkg::lane_t lane_nxt;
  ezr_pkg::lane_t lane_r;

  // One micro-rotation: drive y toward zero.
  always_comb begin
    if (lane_in.y >= 0) begin
      lane_nxt.x = lane_in.x + (lane_in.y >>> STEP);
      lane_nxt.y = lane_in.y - (lane_in.x >>> STEP);
      lane_nxt.z = lane_in.z + ezr_pkg::atan_entry(STEP);
    end else begin
      lane_nxt.x = lane_in.x - (lane_in.y >>> STEP);
      lane_nxt.y = lane_in.y + (lane_in.x >>> STEP);
      lane_nxt.z = lane_in.z - ezr_pkg::atan_entry(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_out = lane_r;

endmodule
`default_nettype wire

// File: sv/ezr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "euler_zyx_from_rotation_defines.svh"
module ezr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_alpha,
  input wire logic [15:0] out_beta,
  input wire logic [1:0]  out_branch
);

  `EZR_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_alpha) && $stable(out_beta), "stalled beat changed")
  `EZR_ASSERT(a_branch, out_valid |-> out_branch != 2'd3, "bad branch code")
  `EZR_ASSERT(a_lock_alpha, out_valid && out_branch != ezr_pkg::BR_REGULAR |-> out_alpha == 16'd0, "alpha not zero in gimbal lock")
  `EZR_ASSERT(a_lock_beta, out_valid && out_branch == ezr_pkg::BR_NEAR_POS |-> out_beta == 16'hCDBC, "beta not -pi/2")
  `EZR_ASSERT_ALWAYS(a_reset, !rst_n |=> !out_valid, "valid after reset")

endmodule

bind euler_zyx_from_rotation ezr_checker u_ezr_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_alpha(out_ch.alpha_z),
  .out_beta(out_ch.beta_y),
  .out_branch(out_ch.branch_taken)
);
`default_nettype wire
